// ===== hdl/tr2u_pkg.sv =====
// shared widths, register codes, control structs and saturation for the
// triangular rank-2 update pipeline; no dependencies
package tr2u_pkg;

  localparam int DW     = 16;              // data width, Q1.15
  localparam int FRAC   = DW - 1;          // fractional bits
  localparam int IDX_W  = 10;              // row / column index width
  localparam int OPW    = DW + 1;          // operand width after conjugation
  localparam int PROD_W = DW + OPW;        // one partial product
  localparam int SUM_W  = PROD_W + 1;      // sum of two partial products
  localparam int WIDE_W = SUM_W - FRAC;    // sum after the rounding shift
  localparam int CFG_W  = 2;               // register index width
  localparam int DATA_BYTES = (10 * DW + 2 * IDX_W + 7) / 8;
  localparam int IN_W   = 8 * DATA_BYTES;  // slave tdata width
  localparam int OUT_W  = 2 * DW;          // master tdata width

  typedef enum logic [CFG_W-1:0] {
    CFG_ALPHA_RE  = 2'd0,
    CFG_ALPHA_IM  = 2'd1,
    CFG_LOWER     = 2'd2,
    CFG_CONJUGATE = 2'd3
  } cfg_idx_e;

  // load enables of the two register stages of a complex multiplier
  typedef struct packed {
    logic prod_en;
    logic sum_en;
  } cmul_ctrl_t;

  // item data that travels beside the arithmetic
  typedef struct packed {
    logic signed [DW-1:0] a_re;
    logic signed [DW-1:0] a_im;
    logic signed [DW-1:0] x0_re;
    logic signed [DW-1:0] x0_im;
    logic signed [DW-1:0] x1_re;
    logic signed [DW-1:0] x1_im;
    logic                 in_tri;
    logic                 zero_im;
  } side_t;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [WIDE_W-1:0] v);
    logic signed [DW-1:0] r;
    if ((&v[WIDE_W-1:DW-1]) || !(|v[WIDE_W-1:DW-1])) begin
      r = v[DW-1:0];
    end else if (v[WIDE_W-1]) begin
      r = {1'b1, {(DW-1){1'b0}}};
    end else begin
      r = {1'b0, {(DW-1){1'b1}}};
    end
    return r;
  endfunction

endpackage

// ===== hdl/tr2u_cmul.sv =====
// two-stage complex multiplier: product registers, then floor shift and
// saturation into result registers; uses tr2u_pkg
module tr2u_cmul
  import tr2u_pkg::*;
(
  input  logic                  clk_i,
  input  cmul_ctrl_t            ctrl_i,
  input  logic signed [DW-1:0]  p_re_i,
  input  logic signed [DW-1:0]  p_im_i,
  input  logic signed [OPW-1:0] q_re_i,
  input  logic signed [OPW-1:0] q_im_i,
  output logic signed [DW-1:0]  r_re_o,
  output logic signed [DW-1:0]  r_im_o
);

  logic signed [PROD_W-1:0] rr_d, ii_d, ri_d, ir_d;
  logic signed [PROD_W-1:0] rr_q, ii_q, ri_q, ir_q;
  logic signed [SUM_W-1:0]  sum_re, sum_im;
  logic signed [WIDE_W-1:0] sh_re, sh_im;
  logic signed [DW-1:0]     r_re_d, r_im_d, r_re_q, r_im_q;

  assign rr_d = p_re_i * q_re_i;
  assign ii_d = p_im_i * q_im_i;
  assign ri_d = p_re_i * q_im_i;
  assign ir_d = p_im_i * q_re_i;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_en) begin
      rr_q <= rr_d;
      ii_q <= ii_d;
      ri_q <= ri_d;
      ir_q <= ir_d;
    end
  end

  assign sum_re = SUM_W'(rr_q) - SUM_W'(ii_q);
  assign sum_im = SUM_W'(ri_q) + SUM_W'(ir_q);
  assign sh_re  = WIDE_W'(sum_re >>> FRAC);
  assign sh_im  = WIDE_W'(sum_im >>> FRAC);
  assign r_re_d = sat_dw(sh_re);
  assign r_im_d = sat_dw(sh_im);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.sum_en) begin
      r_re_q <= r_re_d;
      r_im_q <= r_im_d;
    end
  end

  assign r_re_o = r_re_q;
  assign r_im_o = r_im_q;

endmodule

// ===== hdl/tr2u_acc.sv =====
// final stage: saturated a + t0 + t1, diagonal and outside-triangle cases,
// into the output register; uses tr2u_pkg
module tr2u_acc
  import tr2u_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 en_i,
  input  side_t                side_i,
  input  logic signed [DW-1:0] t0_re_i,
  input  logic signed [DW-1:0] t0_im_i,
  input  logic signed [DW-1:0] t1_re_i,
  input  logic signed [DW-1:0] t1_im_i,
  output logic signed [DW-1:0] new_re_o,
  output logic signed [DW-1:0] new_im_o,
  output logic                 was_updated_o
);

  logic signed [WIDE_W-1:0] sum_re, sum_im;
  logic signed [DW-1:0]     new_re_d, new_im_d, new_re_q, new_im_q;
  logic                     upd_q;

  assign sum_re = WIDE_W'(side_i.a_re) + WIDE_W'(t0_re_i) + WIDE_W'(t1_re_i);
  assign sum_im = WIDE_W'(side_i.a_im) + WIDE_W'(t0_im_i) + WIDE_W'(t1_im_i);

  always_comb begin
    if (!side_i.in_tri) begin
      new_re_d = side_i.a_re;
      new_im_d = side_i.a_im;
    end else begin
      new_re_d = sat_dw(sum_re);
      new_im_d = side_i.zero_im ? '0 : sat_dw(sum_im);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      new_re_q <= new_re_d;
      new_im_q <= new_im_d;
      upd_q    <= side_i.in_tri;
    end
  end

  assign new_re_o      = new_re_q;
  assign new_im_o      = new_im_q;
  assign was_updated_o = upd_q;

endmodule

// ===== hdl/triangular_rank2_update.sv =====
// top level of the triangular rank-2 update element engine: stream ports,
// registers, valid pipeline; uses tr2u_pkg, tr2u_cmul and tr2u_acc
//
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata: a, x0, x1, y0, y1, row, col
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata: new_re, new_im; tuser: was_updated
// cfg       in   cfg_we_i                     cfg_idx_i, cfg_data_i
//
// five register stages: alpha*y products, eta rounding, x*eta products,
// t rounding, output sum; one item per cycle while m_axis_tready does not stall the output
// each stage has its own valid bit and loads when empty or moving on, so
// bubbles close up under a stall and the input stays open until all five fill
// reset clears the valid bits and loads the register reset values
module triangular_rank2_update
  import tr2u_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  // a_re, a_im, x0_re, x0_im, x1_re, x1_im, y0_re, y0_im, y1_re, y1_im,
  // row_index, col_index, zero pad
  input  logic [IN_W-1:0]  s_axis_tdata,
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  // new_re, new_im
  output logic [OUT_W-1:0] m_axis_tdata,
  // was_updated
  output logic             m_axis_tuser,
  input  logic             cfg_we_i,
  input  logic [CFG_W-1:0] cfg_idx_i,
  input  logic [DW-1:0]    cfg_data_i
);

  localparam int NST = 5;

  logic signed [DW-1:0] alpha_re_q, alpha_im_q;
  logic                 lower_q, conj_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_re_q <= {1'b0, {(DW-1){1'b1}}};
      alpha_im_q <= '0;
      lower_q    <= 1'b1;
      conj_q     <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ALPHA_RE:  alpha_re_q <= cfg_data_i;
        CFG_ALPHA_IM:  alpha_im_q <= cfg_data_i;
        CFG_LOWER:     lower_q    <= cfg_data_i[0];
        CFG_CONJUGATE: conj_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // input fields
  logic signed [DW-1:0]  a_re, a_im, x0_re, x0_im, x1_re, x1_im;
  logic signed [DW-1:0]  y0_re, y0_im, y1_re, y1_im;
  logic [IDX_W-1:0]      row_idx, col_idx;
  logic signed [OPW-1:0] q0_re, q0_im, q1_re, q1_im;
  logic                  in_tri;
  side_t                 side_d;

  assign a_re    = s_axis_tdata[0*DW +: DW];
  assign a_im    = s_axis_tdata[1*DW +: DW];
  assign x0_re   = s_axis_tdata[2*DW +: DW];
  assign x0_im   = s_axis_tdata[3*DW +: DW];
  assign x1_re   = s_axis_tdata[4*DW +: DW];
  assign x1_im   = s_axis_tdata[5*DW +: DW];
  assign y0_re   = s_axis_tdata[6*DW +: DW];
  assign y0_im   = s_axis_tdata[7*DW +: DW];
  assign y1_re   = s_axis_tdata[8*DW +: DW];
  assign y1_im   = s_axis_tdata[9*DW +: DW];
  assign row_idx = s_axis_tdata[10*DW +: IDX_W];
  assign col_idx = s_axis_tdata[10*DW+IDX_W +: IDX_W];

  assign q0_re = OPW'(y0_re);
  assign q1_re = OPW'(y1_re);
  assign q0_im = conj_q ? -OPW'(y0_im) : OPW'(y0_im);
  assign q1_im = conj_q ? -OPW'(y1_im) : OPW'(y1_im);

  assign in_tri = lower_q ? (row_idx >= col_idx) : (row_idx <= col_idx);

  always_comb begin
    side_d.a_re    = a_re;
    side_d.a_im    = a_im;
    side_d.x0_re   = x0_re;
    side_d.x0_im   = x0_im;
    side_d.x1_re   = x1_re;
    side_d.x1_im   = x1_im;
    side_d.in_tri  = in_tri;
    side_d.zero_im = conj_q && (row_idx == col_idx);
  end

  // valid bits and stage enables
  logic [NST-1:0] vld_q, vld_d, rdy;

  always_comb begin
    rdy[NST-1] = !vld_q[NST-1] || m_axis_tready;
    for (int k = NST - 2; k >= 0; k--) begin
      rdy[k] = !vld_q[k] || rdy[k+1];
    end
    vld_d[0] = rdy[0] ? s_axis_tvalid : vld_q[0];
    for (int k = 1; k < NST; k++) begin
      vld_d[k] = rdy[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign s_axis_tready = rdy[0];
  assign m_axis_tvalid = vld_q[NST-1];

  // side data for stages one to four
  side_t side_q [NST-1];

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      side_q[0] <= side_d;
    end
    for (int k = 1; k < NST - 1; k++) begin
      if (rdy[k]) begin
        side_q[k] <= side_q[k-1];
      end
    end
  end

  cmul_ctrl_t ctrl_eta, ctrl_t;
  logic signed [DW-1:0] e0_re, e0_im, e1_re, e1_im;
  logic signed [DW-1:0] t0_re, t0_im, t1_re, t1_im;
  logic signed [DW-1:0] new_re, new_im;

  assign ctrl_eta = '{prod_en: rdy[0], sum_en: rdy[1]};
  assign ctrl_t   = '{prod_en: rdy[2], sum_en: rdy[3]};

  tr2u_cmul u_eta0 (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_eta),
    .p_re_i (alpha_re_q),
    .p_im_i (alpha_im_q),
    .q_re_i (q0_re),
    .q_im_i (q0_im),
    .r_re_o (e0_re),
    .r_im_o (e0_im)
  );

  tr2u_cmul u_eta1 (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_eta),
    .p_re_i (alpha_re_q),
    .p_im_i (alpha_im_q),
    .q_re_i (q1_re),
    .q_im_i (q1_im),
    .r_re_o (e1_re),
    .r_im_o (e1_im)
  );

  tr2u_cmul u_t0 (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_t),
    .p_re_i (side_q[1].x0_re),
    .p_im_i (side_q[1].x0_im),
    .q_re_i (OPW'(e0_re)),
    .q_im_i (OPW'(e0_im)),
    .r_re_o (t0_re),
    .r_im_o (t0_im)
  );

  tr2u_cmul u_t1 (
    .clk_i  (clk_i),
    .ctrl_i (ctrl_t),
    .p_re_i (side_q[1].x1_re),
    .p_im_i (side_q[1].x1_im),
    .q_re_i (OPW'(e1_re)),
    .q_im_i (OPW'(e1_im)),
    .r_re_o (t1_re),
    .r_im_o (t1_im)
  );

  tr2u_acc u_acc (
    .clk_i         (clk_i),
    .en_i          (rdy[NST-1]),
    .side_i        (side_q[NST-2]),
    .t0_re_i       (t0_re),
    .t0_im_i       (t0_im),
    .t1_re_i       (t1_re),
    .t1_im_i       (t1_im),
    .new_re_o      (new_re),
    .new_im_o      (new_im),
    .was_updated_o (m_axis_tuser)
  );

  assign m_axis_tdata = {new_im, new_re};

  logic in_acc, out_acc;
  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // input only closes when every stage holds an item
  a_full_when_blocked : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("input blocked with an empty stage");

  // items in flight change only by accepted and delivered items
  a_item_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni) |->
      ($countones(vld_q) + $past(out_acc) == $past($countones(vld_q)) + $past(in_acc)))
    else $error("item lost or duplicated in pipeline");

endmodule
